// ===== sv/htq_pkg.sv =====
// ----------------------------------------------------------------------------
// htq_pkg
// shared types, codes and the wraparound compare for the heap timer queue
// ----------------------------------------------------------------------------
package htq_pkg;

  localparam int ID_W    = 5;
  localparam int NUM_IDS = 32;
  localparam int TICK_W  = 32;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PENDING = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] exp;
    logic [ID_W-1:0]   own;
  } heap_ent_t;

  // true when a is strictly after b, modulo 2^32
  function automatic logic later_than(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] d;
    d = b - a;
    return d[TICK_W-1];
  endfunction

endpackage

// ===== sv/htq_if.sv =====
// ----------------------------------------------------------------------------
// htq channel interfaces
// command channel and result channel, valid/ready
// ----------------------------------------------------------------------------
interface htq_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [htq_pkg::ID_W-1:0]   timer_id;
  logic [htq_pkg::TICK_W-1:0] expiry_tick;

  modport source (output valid, cmd, timer_id, expiry_tick, input ready);
  modport sink   (input valid, cmd, timer_id, expiry_tick, output ready);
endinterface

interface htq_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [htq_pkg::ID_W-1:0]   fired_id;
  logic [1:0]                 status;
  logic [5:0]                 pending_count;
  logic [htq_pkg::TICK_W-1:0] now_tick;
  logic                       last;

  modport source (output valid, kind, fired_id, status, pending_count, now_tick, last,
                  input ready);
  modport sink   (input valid, kind, fired_id, status, pending_count, now_tick, last,
                  output ready);
endinterface

// ===== sv/htq_ram.sv =====
// ----------------------------------------------------------------------------
// htq_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module htq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== sv/heap_timer_queue.sv =====
// ----------------------------------------------------------------------------
// heap_timer_queue
// pending timers in a binary min-heap keyed by wrapping expiry tick
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_ch   | in  | cmd, timer_id, expiry_tick
//  out_ch  | out | kind, fired_id, status, pending_count, now_tick, last
//
// one command at a time, paced by the single read port of the heap ram: an add
// climbs a level per parent read and compare; a delete reads the id's slot
// and, unless that is the last one, refills the hole with the last entry and
// climbs or sinks, reading both children per level; a tick pops and sinks each
// due root, then ends on a root that is not due or on an empty heap
// no clearing pass: the rams are only read where written, pending bits reset
// a result waits in the output register; a stalled output halts the sequencer
// ----------------------------------------------------------------------------
module heap_timer_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  htq_in_if.sink           in_ch,
  htq_out_if.source        out_ch
);

  localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = SW + 2;
  localparam int EW = $bits(htq_pkg::heap_ent_t);

  typedef enum logic [3:0] {
    S_IDLE, S_DEL_SLOT, S_DEL_LAST, S_UP_RD, S_UP_CMP,
    S_DN_RDL, S_DN_L, S_DN_CMP, S_TK_RD, S_TK_CHK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [htq_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [htq_pkg::NUM_IDS-1:0] pend_r, pend_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  htq_pkg::heap_ent_t x_r, x_nxt, l_r, l_nxt;
  logic has_right_r, has_right_nxt;
  logic first_r, first_nxt;
  logic tick_mode_r, tick_mode_nxt;
  logic held_r, held_nxt;
  logic [htq_pkg::ID_W-1:0] held_id_r, held_id_nxt;
  logic [CW-1:0] held_cnt_r, held_cnt_nxt;
  logic [1:0] status_r, status_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [htq_pkg::ID_W-1:0] out_fired_r, out_fired_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [5:0] out_count_r, out_count_nxt;
  logic [htq_pkg::TICK_W-1:0] out_tick_r, out_tick_nxt;
  logic out_last_r, out_last_nxt;

  // ram ports
  logic heap_we, heap_re, slot_we, slot_re;
  logic [SW-1:0] heap_wa, heap_ra, slot_wd, slot_rd;
  htq_pkg::heap_ent_t heap_wd, heap_rd;
  logic [htq_pkg::ID_W-1:0] slot_wa, slot_ra;

  // heap entries: expiry and owner id
  htq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_heap (
    .clk(clk), .we(heap_we), .wa(heap_wa), .wd(heap_wd),
    .re(heap_re), .ra(heap_ra), .rd(heap_rd)
  );

  // heap slot of each id
  htq_ram #(.WIDTH(SW), .DEPTH(htq_pkg::NUM_IDS)) u_slot (
    .clk(clk), .we(slot_we), .wa(slot_wa), .wd(slot_wd),
    .re(slot_re), .ra(slot_ra), .rd(slot_rd)
  );

  logic can_emit;
  logic [SW-1:0] par_idx;
  logic [IW-1:0] cidx;
  logic [CW-1:0] size_dec;
  logic due;
  logic pick_l, pick_r;
  htq_pkg::heap_ent_t best;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign par_idx  = (idx_r - 1'b1) >> 1;
  assign cidx     = {2'b00, idx_r} * IW'(2) + IW'(1);
  assign size_dec = size_r - 1'b1;
  assign due      = !htq_pkg::later_than(heap_rd.exp, tick_r);

  // sift-down choice: left only if strictly earlier, right only if strictly
  // earlier than the current best
  always_comb begin
    pick_l = htq_pkg::later_than(x_r.exp, l_r.exp);
    best   = pick_l ? l_r : x_r;
    pick_r = has_right_r && htq_pkg::later_than(best.exp, heap_rd.exp);
    if (pick_r) begin
      best = heap_rd;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    tick_nxt       = tick_r;
    pend_nxt       = pend_r;
    idx_nxt        = idx_r;
    x_nxt          = x_r;
    l_nxt          = l_r;
    has_right_nxt  = has_right_r;
    first_nxt      = first_r;
    tick_mode_nxt  = tick_mode_r;
    held_nxt       = held_r;
    held_id_nxt    = held_id_r;
    held_cnt_nxt   = held_cnt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_fired_nxt  = out_fired_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_tick_nxt   = out_tick_r;
    out_last_nxt   = out_last_r;
    heap_we = 1'b0;
    heap_wa = idx_r;
    heap_wd = x_r;
    heap_re = 1'b0;
    heap_ra = '0;
    slot_we = 1'b0;
    slot_wa = x_r.own;
    slot_wd = idx_r;
    slot_re = 1'b0;
    slot_ra = in_ch.timer_id;
    in_ch.ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          status_nxt = htq_pkg::ST_OK;
          case (in_ch.cmd)
            htq_pkg::CMD_ADD: begin
              if (pend_r[in_ch.timer_id]) begin
                status_nxt = htq_pkg::ST_PENDING;
                state_nxt  = S_DONE;
              end else if (size_r == CW'(QUEUE_DEPTH)) begin
                status_nxt = htq_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt   = SW'(size_r);
                size_nxt  = size_r + 1'b1;
                x_nxt     = '{exp: in_ch.expiry_tick, own: in_ch.timer_id};
                pend_nxt[in_ch.timer_id] = 1'b1;
                first_nxt = 1'b0;
                tick_mode_nxt = 1'b0;
                state_nxt = S_UP_RD;
              end
            end
            htq_pkg::CMD_DEL: begin
              if (!pend_r[in_ch.timer_id]) begin
                status_nxt = htq_pkg::ST_ABSENT;
                state_nxt  = S_DONE;
              end else begin
                pend_nxt[in_ch.timer_id] = 1'b0;
                slot_re       = 1'b1;
                tick_mode_nxt = 1'b0;
                state_nxt     = S_DEL_SLOT;
              end
            end
            htq_pkg::CMD_TICK: begin
              tick_nxt      = tick_r + 1'b1;
              held_nxt      = 1'b0;
              tick_mode_nxt = 1'b1;
              state_nxt     = S_TK_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_DEL_SLOT: begin
        idx_nxt  = slot_rd;
        size_nxt = size_dec;
        if (CW'(slot_rd) < size_dec) begin
          heap_re   = 1'b1;
          heap_ra   = SW'(size_dec);
          state_nxt = S_DEL_LAST;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // last entry fills the hole
      S_DEL_LAST: begin
        x_nxt     = heap_rd;
        first_nxt = 1'b1;
        state_nxt = S_UP_RD;
      end

      S_UP_RD: begin
        if (idx_r == '0) begin
          if (first_r) begin
            state_nxt = S_DN_RDL;
          end else begin
            heap_we   = 1'b1;
            slot_we   = 1'b1;
            state_nxt = tick_mode_r ? S_TK_RD : S_DONE;
          end
        end else begin
          heap_re   = 1'b1;
          heap_ra   = par_idx;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (htq_pkg::later_than(heap_rd.exp, x_r.exp)) begin
          heap_we   = 1'b1;
          heap_wd   = heap_rd;
          slot_we   = 1'b1;
          slot_wa   = heap_rd.own;
          idx_nxt   = par_idx;
          first_nxt = 1'b0;
          state_nxt = S_UP_RD;
        end else if (first_r) begin
          state_nxt = S_DN_RDL;
        end else begin
          heap_we   = 1'b1;
          slot_we   = 1'b1;
          state_nxt = tick_mode_r ? S_TK_RD : S_DONE;
        end
      end

      S_DN_RDL: begin
        if (cidx >= IW'(size_r)) begin
          heap_we   = 1'b1;
          slot_we   = 1'b1;
          state_nxt = tick_mode_r ? S_TK_RD : S_DONE;
        end else begin
          heap_re   = 1'b1;
          heap_ra   = SW'(cidx);
          state_nxt = S_DN_L;
        end
      end

      S_DN_L: begin
        l_nxt         = heap_rd;
        has_right_nxt = (cidx + IW'(1)) < IW'(size_r);
        if ((cidx + IW'(1)) < IW'(size_r)) begin
          heap_re = 1'b1;
          heap_ra = SW'(cidx + IW'(1));
        end
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (pick_l || pick_r) begin
          heap_wd   = best;
          slot_wa   = best.own;
          idx_nxt   = pick_r ? SW'(cidx + IW'(1)) : SW'(cidx);
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = tick_mode_r ? S_TK_RD : S_DONE;
        end
      end

      S_TK_RD: begin
        if (size_r == '0) begin
          if (can_emit) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = held_r ? htq_pkg::KIND_FIRED : htq_pkg::KIND_IDLE;
            out_fired_nxt  = held_r ? held_id_r : '0;
            out_status_nxt = htq_pkg::ST_OK;
            out_count_nxt  = held_r ? 6'(held_cnt_r) : 6'(size_r);
            out_tick_nxt   = tick_r;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          heap_re   = 1'b1;
          heap_ra   = '0;
          state_nxt = S_TK_CHK;
        end
      end

      // root is due: report the previous pop as not last, pop this one; else report last
      S_TK_CHK: begin
        if (due) begin
          if (!held_r || can_emit) begin
            if (held_r) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = htq_pkg::KIND_FIRED;
              out_fired_nxt  = held_id_r;
              out_status_nxt = htq_pkg::ST_OK;
              out_count_nxt  = 6'(held_cnt_r);
              out_tick_nxt   = tick_r;
              out_last_nxt   = 1'b0;
            end
            held_nxt     = 1'b1;
            held_id_nxt  = heap_rd.own;
            held_cnt_nxt = size_dec;
            pend_nxt[heap_rd.own] = 1'b0;
            size_nxt     = size_dec;
            idx_nxt      = '0;
            if (size_dec != '0) begin
              heap_re   = 1'b1;
              heap_ra   = SW'(size_dec);
              state_nxt = S_DEL_LAST;
            end else begin
              state_nxt = S_TK_RD;
            end
          end
        end else if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = held_r ? htq_pkg::KIND_FIRED : htq_pkg::KIND_IDLE;
          out_fired_nxt  = held_r ? held_id_r : '0;
          out_status_nxt = htq_pkg::ST_OK;
          out_count_nxt  = held_r ? 6'(held_cnt_r) : 6'(size_r);
          out_tick_nxt   = tick_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_DONE: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = htq_pkg::KIND_ACK;
          out_fired_nxt  = '0;
          out_status_nxt = status_r;
          out_count_nxt  = 6'(size_r);
          out_tick_nxt   = tick_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      tick_r      <= '0;
      pend_r      <= '0;
      held_r      <= 1'b0;
      tick_mode_r <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      tick_r      <= tick_nxt;
      pend_r      <= pend_nxt;
      held_r      <= held_nxt;
      tick_mode_r <= tick_mode_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    x_r          <= x_nxt;
    l_r          <= l_nxt;
    has_right_r  <= has_right_nxt;
    held_id_r    <= held_id_nxt;
    held_cnt_r   <= held_cnt_nxt;
    status_r     <= status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_fired_r  <= out_fired_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_tick_r   <= out_tick_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.fired_id      = out_fired_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.pending_count = out_count_r;
  assign out_ch.now_tick      = out_tick_r;
  assign out_ch.last          = out_last_r;

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CW'(QUEUE_DEPTH))
    else $error("heap size beyond depth");

  a_pend_matches_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(pend_r) == int'(size_r)))
    else $error("pending bits disagree with heap size");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == htq_pkg::KIND_FIRED) |-> out_status_r == htq_pkg::ST_OK)
    else $error("expiry beat with nonzero status");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("command accepted without leaving idle");
`endif

endmodule
